@@ sv/assert_macros.svh @@
// assertion macros for the indicator rtl, used by msdi_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define MSDI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define MSDI_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/msdi_pkg.sv @@
// types, constants and codes for the multi-sensor distance indicator
`timescale 1ns / 1ps
`default_nettype none
package msdi_pkg;

	localparam int MAX_SENSORS = 8;
	localparam int IDX_W       = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CNT_W       = $clog2(MAX_SENSORS + 1);
	localparam int ID_W        = 8;
	localparam int DIST_W      = 13;
	localparam int HALF_W      = 12;
	localparam int FUNC_W      = 2;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int SUM_W       = DIST_W + CNT_W;
	localparam int STEP_W      = $clog2(SUM_W);

	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_SENSORS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

	localparam logic [DIST_W-1:0] BLINK_LIMIT_RST = DIST_W'(300);
	localparam logic [DIST_W-1:0] ON_LIMIT_RST    = DIST_W'(50);

	localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE     = 2'd3;

	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLINK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ON    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_mm;
		logic              known;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		entry_t            entry;
	} tbl_wr_t;

	typedef struct packed {
		logic [DIST_W-1:0] blink_limit;
		logic [DIST_W-1:0] on_limit;
		logic              output_enable;
	} cfg_t;

endpackage
`default_nettype wire

@@ sv/msdi_table.sv @@
// sensor table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module msdi_table (
	input  wire logic                        clk,
	input  wire msdi_pkg::tbl_wr_t           wr,
	input  wire logic [msdi_pkg::IDX_W-1:0]  rd_addr,
	output msdi_pkg::entry_t                 rd_data_q
);
	import msdi_pkg::*;

	entry_t mem_q [MAX_SENSORS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
		rd_data_q <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ sv/msdi_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module msdi_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [msdi_pkg::SUM_W-1:0]  dividend,
	input  wire logic [msdi_pkg::CNT_W-1:0]  divisor,
	output logic                             busy,
	output logic                             done,
	output logic [msdi_pkg::SUM_W-1:0]       quotient
);
	import msdi_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [SUM_W-1:0]  quo_q;

	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ sv/msdi_seq.sv @@
// sequencer: table walk, sum of known distances, result word
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module msdi_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire msdi_pkg::cfg_t                cfg,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [msdi_pkg::FUNC_W-1:0]   func,
	input  wire logic [msdi_pkg::ID_W-1:0]     sensor_id,
	input  wire logic [msdi_pkg::DIST_W-1:0]   distance,
	input  wire logic                          distance_known,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               is_drive,
	output logic [msdi_pkg::MODE_W-1:0]        drive_mode,
	output logic [msdi_pkg::HALF_W-1:0]        blink_half_period,
	output logic                               op_ok,
	output msdi_pkg::tbl_wr_t                  tbl_wr,
	output logic [msdi_pkg::IDX_W-1:0]         rd_addr,
	input  wire msdi_pkg::entry_t              rd_data_q,
	output logic                               div_start,
	output logic [msdi_pkg::SUM_W-1:0]         div_dividend,
	output logic [msdi_pkg::CNT_W-1:0]         div_divisor,
	input  wire logic                          div_busy,
	input  wire logic                          div_done,
	input  wire logic [msdi_pkg::SUM_W-1:0]    div_quotient
);
	import msdi_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_FINISH = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_RES    = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              found_q;
	logic              out_valid_q;

	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [DIST_W-1:0] dist_q;
	logic              dknown_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  kcnt_q;
	logic              is_drive_q;
	logic [MODE_W-1:0] mode_q;
	logic [HALF_W-1:0] half_q;
	logic              ok_q;

	logic              in_acc;
	logic              issue;
	logic              match;
	logic              use_new;
	logic              add_known;
	logic [DIST_W-1:0] add_dist;
	logic              reg_ok;
	logic              out_free;
	logic              res_load;
	logic              res_drive;
	logic [MODE_W-1:0] res_mode;
	logic [HALF_W-1:0] res_half;
	logic              res_ok;
	logic              commit;

	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign issue     = (state_q == ST_WALK) && (ptr_q < cnt_q);
	assign rd_addr   = ptr_q[IDX_W-1:0];
	assign match     = rd_vld_s1 && (rd_data_q.id == id_q);
	assign use_new   = (func_q == FUNC_UPDATE) && match;
	assign add_known = use_new ? dknown_q : rd_data_q.known;
	assign add_dist  = use_new ? dist_q : rd_data_q.dist_mm;
	assign reg_ok    = !found_q && (cnt_q < CNT_MAX);
	assign out_free  = !out_valid_q || !out_stall;

	assign div_start    = (state_q == ST_FINISH) && (func_q == FUNC_UPDATE)
		&& cfg.output_enable && (kcnt_q != '0);
	assign div_dividend = sum_q;
	assign div_divisor  = kcnt_q;

	// result word
	always_comb begin
		res_load  = 1'b0;
		res_drive = 1'b0;
		res_mode  = MODE_OFF;
		res_half  = '0;
		res_ok    = 1'b0;
		if (state_q == ST_FINISH
			&& (func_q == FUNC_REGISTER || func_q == FUNC_REMOVE)) begin
			res_load = out_free;
			res_ok   = (func_q == FUNC_REGISTER) ? reg_ok : found_q;
		end else if (state_q == ST_RES) begin
			res_load  = out_free;
			res_drive = 1'b1;
			if (kcnt_q == '0) begin
				res_mode = MODE_OFF;
			end else if (div_quotient > SUM_W'(cfg.blink_limit)) begin
				res_mode = MODE_OFF;
			end else if (div_quotient > SUM_W'(cfg.on_limit)) begin
				res_mode = MODE_BLINK;
				res_half = div_quotient[HALF_W:1];
			end else begin
				res_mode = MODE_ON;
			end
		end
	end

	assign commit = (state_q == ST_FINISH) && res_load;

	// table write
	always_comb begin
		tbl_wr = '0;
		if (state_q == ST_WALK && rd_vld_s1) begin
			if (use_new) begin
				tbl_wr.en    = 1'b1;
				tbl_wr.addr  = rd_idx_s1;
				tbl_wr.entry = '{id: id_q, dist_mm: dist_q, known: dknown_q};
			end else if (func_q == FUNC_REMOVE && found_q) begin
				tbl_wr.en    = 1'b1;
				tbl_wr.addr  = rd_idx_s1 - IDX_W'(1);
				tbl_wr.entry = rd_data_q;
			end
		end else if (commit && func_q == FUNC_REGISTER && reg_ok) begin
			tbl_wr.en    = 1'b1;
			tbl_wr.addr  = cnt_q[IDX_W-1:0];
			tbl_wr.entry = '{id: id_q, dist_mm: '0, known: 1'b0};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && func != FUNC_NONE) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!issue && !rd_vld_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (func_q == FUNC_UPDATE) begin
					if (!cfg.output_enable) begin
						state_d = ST_IDLE;
					end else if (kcnt_q == '0) begin
						state_d = ST_RES;
					end else begin
						state_d = ST_DIV;
					end
				end else if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (in_acc) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				if (state_q == ST_WALK && match) begin
					found_q <= 1'b1;
				end
			end
			if (commit) begin
				if (func_q == FUNC_REGISTER && reg_ok) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (func_q == FUNC_REMOVE && found_q) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q   <= func;
			id_q     <= sensor_id;
			dist_q   <= distance;
			dknown_q <= distance_known;
			sum_q    <= '0;
			kcnt_q   <= '0;
		end else if (state_q == ST_WALK && rd_vld_s1 && add_known) begin
			sum_q  <= sum_q + SUM_W'(add_dist);
			kcnt_q <= kcnt_q + CNT_W'(1);
		end
		rd_idx_s1 <= ptr_q[IDX_W-1:0];
		if (res_load) begin
			is_drive_q <= res_drive;
			mode_q     <= res_mode;
			half_q     <= res_half;
			ok_q       <= res_ok;
		end
	end

	assign out_valid         = out_valid_q;
	assign is_drive          = is_drive_q;
	assign drive_mode        = mode_q;
	assign blink_half_period = half_q;
	assign op_ok             = ok_q;

	`MSDI_ASSERT(a_cnt_range, cnt_q <= CNT_MAX, "entry count above table size")
	`MSDI_IMPLY(a_cnt_step, cnt_q != $past(cnt_q), $past(state_q) == ST_FINISH, "count moved outside finish")
	`MSDI_IMPLY(a_drive_word, out_valid_q && is_drive_q, !ok_q, "drive word with op_ok set")
	`MSDI_IMPLY(a_reply_word, out_valid_q && !is_drive_q, mode_q == MODE_OFF && half_q == '0, "reply word with drive fields")
	`MSDI_IMPLY(a_div_idle, div_start, !div_busy, "divider started while busy")

endmodule
`default_nettype wire

@@ sv/multi_sensor_distance_indicator_core.sv @@
// Top level of the multi-sensor distance indicator.
// Input channel (in_valid / in_stall) takes one word per operation: a distance
// update, a sensor register or a sensor remove, keyed by sensor_id.
// Output channel (out_valid / out_stall) gives one word per register or remove
// (op_ok) and, with output_enable set, one drive word per update.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
// blink_limit, on_limit and output_enable; cfg_ready is always high.
// An operation walks the sensor table one entry a cycle through the registered
// memory port and then finishes (register and remove commit there); an update
// with output_enable set also runs a serial divide when the table holds a known
// distance, and then a result step. in_stall is high for all of that time and
// the next word is taken the cycle after.
// The finished word sits in an output register, so a stall on the output only
// holds the block once a second word is ready.
// Reset empties the table and loads the default limits (300, 50, enabled).
`timescale 1ns / 1ps
`default_nettype none
module multi_sensor_distance_indicator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [msdi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [msdi_pkg::DIST_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [msdi_pkg::FUNC_W-1:0]      func,
	input  wire logic [msdi_pkg::ID_W-1:0]        sensor_id,
	input  wire logic [msdi_pkg::DIST_W-1:0]      distance,
	input  wire logic                             distance_known,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  is_drive,
	output logic [msdi_pkg::MODE_W-1:0]           drive_mode,
	output logic [msdi_pkg::HALF_W-1:0]           blink_half_period,
	output logic                                  op_ok
);
	import msdi_pkg::*;

	cfg_t             cfg_q;
	tbl_wr_t          tbl_wr;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data_q;
	logic             div_start;
	logic [SUM_W-1:0] div_dividend;
	logic [CNT_W-1:0] div_divisor;
	logic             div_busy;
	logic             div_done;
	logic [SUM_W-1:0] div_quotient;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_limit   <= BLINK_LIMIT_RST;
			cfg_q.on_limit      <= ON_LIMIT_RST;
			cfg_q.output_enable <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BLINK_LIMIT:   cfg_q.blink_limit   <= cfg_data;
				CFG_ON_LIMIT:      cfg_q.on_limit      <= cfg_data;
				CFG_OUTPUT_ENABLE: cfg_q.output_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	msdi_table u_table (
		.clk       (clk),
		.wr        (tbl_wr),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	msdi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	msdi_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.func              (func),
		.sensor_id         (sensor_id),
		.distance          (distance),
		.distance_known    (distance_known),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.is_drive          (is_drive),
		.drive_mode        (drive_mode),
		.blink_half_period (blink_half_period),
		.op_ok             (op_ok),
		.tbl_wr            (tbl_wr),
		.rd_addr           (rd_addr),
		.rd_data_q         (rd_data_q),
		.div_start         (div_start),
		.div_dividend      (div_dividend),
		.div_divisor       (div_divisor),
		.div_busy          (div_busy),
		.div_done          (div_done),
		.div_quotient      (div_quotient)
	);

endmodule
`default_nettype wire
